@@ hw/rtl/atrrp_pkg.sv @@
// Shared types, constants and token matching for the AT response and request parser.
`timescale 1ns / 1ps
`default_nettype none

package atrrp_pkg;

   // Sizes of the connection table and the value store.
   localparam int CONNECTIONS = 5;
   localparam int VALUE_LEN   = 30;
   localparam int SLOT_LEN    = VALUE_LEN + 1;
   localparam int STORE_DEPTH = CONNECTIONS * SLOT_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CIDX_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

   // Search limits in bytes.
   localparam int GET_LIMIT = 13;
   localparam int REQ_LIMIT = 6;
   localparam int CNT_MAX   = (VALUE_LEN > GET_LIMIT) ? VALUE_LEN : GET_LIMIT;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);

   // Field widths of the stream words.
   localparam int KIND_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int CONN_W    = 3;
   localparam int INDEX_W   = 5;
   localparam int PEND_W    = 5;
   localparam int ANSWER_W  = 4;
   localparam int MODE_W    = 3;
   localparam int CMD_W     = 2;

   // Characters the matcher looks for.
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_GT    = 8'h3E;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [ANSWER_W-1:0] {
      ANS_NONE   = 4'd0,
      ANS_OK     = 4'd1,
      ANS_ERROR  = 4'd2,
      ANS_PROMPT = 4'd3,
      ANS_IPD    = 4'd4,
      ANS_GET    = 4'd5,
      ANS_TEXT   = 4'd6,
      ANS_LED    = 4'd7,
      ANS_HTTP   = 4'd8,
      ANS_HDR_END = 4'd9
   } answer_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_UNKNOWN = 2'd0,
      CMD_PAGE    = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_LED     = 2'd3
   } command_type;

   // Five-byte receive window, byte 4 is the newest.
   typedef logic [4:0][7:0] window_type;

   // Token found in a window, plus the ready marker.
   typedef struct packed {
      answer_type code;
      logic       ready;
   } token_type;

   // Status after one word has been applied.
   typedef struct packed {
      answer_type           answer;
      logic [MODE_W-1:0]    mode;
      logic                 busy;
      logic                 restart;
      logic [PEND_W-1:0]    pending;
      logic [CONN_W-1:0]    conn;
      command_type          command;
   } status_type;

   // One write into the value store.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // Store address of a byte of one connection's value.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [CONN_W-1:0] conn,
                                                   input logic [CNT_W+1:0] pos);
      store_addr = ADDR_W'(ADDR_W'(conn) * ADDR_W'(SLOT_LEN) + ADDR_W'(pos));
   endfunction

   // Match the window against the response tokens, first hit wins.
   function automatic token_type match_token(input window_type w);
      token_type t;
      t.code  = ANS_NONE;
      t.ready = 1'b0;
      if (w[2] == "O" && w[3] == "K" && w[4] == CH_CR) begin
         t.code = ANS_OK;
      end else if (w[0] == "E" && w[1] == "R" && w[2] == "R") begin
         t.code = ANS_ERROR;
      end else if (w[2] == CH_LF && w[3] == CH_GT && w[4] == CH_SPACE) begin
         t.code = ANS_PROMPT;
      end else if (w[0] == "I" && w[1] == "P" && w[2] == "D" && w[3] == ",") begin
         t.code = ANS_IPD;
      end else if (w[0] == "G" && w[1] == "E" && w[2] == "T" && w[3] == CH_SPACE
                   && w[4] == "/") begin
         t.code = ANS_GET;
      end else if (w[2] == CH_QUEST && w[4] == "=") begin
         if (w[3] == "T") begin
            t.code = ANS_TEXT;
         end else if (w[3] == "L") begin
            t.code = ANS_LED;
         end else begin
            t.code = ANS_HTTP;
         end
      end else if (w[2] == "/" && w[3] == CH_SPACE && w[4] == "H") begin
         t.code = ANS_HTTP;
      end else if (w[2] == CH_CR && w[3] == CH_LF && w[4] == CH_CR) begin
         t.code = ANS_HDR_END;
      end else if (w[0] == "a" && w[1] == "d" && w[2] == "y" && w[3] == CH_CR
                   && w[4] == CH_LF) begin
         t.ready = 1'b1;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/atrrp_parser.sv @@
// Receive window, token matcher and request mode machine.
`timescale 1ns / 1ps
`default_nettype none

module atrrp_parser
   import atrrp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire kind_type           kind,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [CONN_W-1:0]  conn_sel,
   output status_type              status,
   output store_wr_type            store_wr
);

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_AWAIT_ANY = 3'd1,
      MODE_AWAIT_GET = 3'd2,
      MODE_AWAIT_REQ = 3'd3,
      MODE_VALUE     = 3'd4,
      MODE_AWAIT_END = 3'd5
   } mode_type;

   window_type                    window_ff, window_in;
   mode_type                      mode_ff, mode_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CONN_W-1:0]             conn_ff, conn_in;
   answer_type                    answer_ff, answer_in;
   logic                          busy_ff, busy_in;
   logic                          restart_ff, restart_in;
   logic [CONNECTIONS-1:0]        flags_ff, flags_in;
   command_type                   cmds_ff [CONNECTIONS];
   command_type                   cmds_in [CONNECTIONS];

   window_type                    win_new;
   token_type                     tok;
   logic [7:0]                    digit;
   logic                          conn_ok;
   logic                          sel_ok;

   // The window as it stands once the new byte is shifted in.
   assign win_new = {rx_byte, window_ff[4:1]};
   assign tok     = match_token(win_new);
   assign digit   = rx_byte - CH_ZERO;
   assign conn_ok = ({1'b0, conn_ff} < (CONN_W + 1)'(CONNECTIONS));
   assign sel_ok  = ({1'b0, conn_sel} < (CONN_W + 1)'(CONNECTIONS));

   // Next state for one accepted word.
   always_comb begin
      window_in  = window_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      conn_in    = conn_ff;
      answer_in  = answer_ff;
      busy_in    = busy_ff;
      restart_in = restart_ff;
      flags_in   = flags_ff;
      cmds_in    = cmds_ff;
      store_wr.we   = 1'b0;
      store_wr.addr = store_addr(conn_ff, (CNT_W + 2)'(count_ff));
      store_wr.data = rx_byte;

      if (accept) begin
         unique case (kind)
            KIND_BYTE: begin
               window_in = win_new;
               unique case (mode_ff)
                  MODE_AWAIT_ANY: begin
                     answer_in  = tok.code;
                     restart_in = restart_ff | tok.ready;
                     mode_in    = MODE_AWAIT_ANY;
                     count_in   = '0;
                     if (tok.code == ANS_IPD) begin
                        busy_in = 1'b1;
                        if (rx_byte >= CH_ZERO && digit < 8'(CONNECTIONS)) begin
                           conn_in = CONN_W'(digit);
                           mode_in = MODE_AWAIT_GET;
                        end
                     end
                  end
                  MODE_AWAIT_GET: begin
                     if (count_ff < CNT_W'(GET_LIMIT)) begin
                        count_in   = count_ff + 1'b1;
                        answer_in  = tok.code;
                        restart_in = restart_ff | tok.ready;
                        if (tok.code == ANS_GET) begin
                           mode_in  = MODE_AWAIT_REQ;
                           count_in = '0;
                           if (conn_ok) begin
                              cmds_in[conn_ff[CIDX_W-1:0]] = CMD_UNKNOWN;
                           end
                        end
                     end else begin
                        mode_in = MODE_AWAIT_END;
                     end
                  end
                  MODE_AWAIT_REQ: begin
                     if (count_ff < CNT_W'(REQ_LIMIT)) begin
                        count_in   = count_ff + 1'b1;
                        answer_in  = tok.code;
                        restart_in = restart_ff | tok.ready;
                        if (tok.code == ANS_HTTP) begin
                           mode_in = MODE_AWAIT_END;
                           if (conn_ok) begin
                              cmds_in[conn_ff[CIDX_W-1:0]]  = CMD_PAGE;
                              flags_in[conn_ff[CIDX_W-1:0]] = 1'b1;
                           end
                        end else if (tok.code == ANS_TEXT || tok.code == ANS_LED) begin
                           mode_in  = MODE_VALUE;
                           count_in = '0;
                           if (conn_ok) begin
                              cmds_in[conn_ff[CIDX_W-1:0]] =
                                 (tok.code == ANS_TEXT) ? CMD_TEXT : CMD_LED;
                           end
                        end
                     end else begin
                        // Request marker not found: flag with unknown command.
                        mode_in  = MODE_AWAIT_ANY;
                        count_in = '0;
                        if (conn_ok) begin
                           flags_in[conn_ff[CIDX_W-1:0]] = 1'b1;
                        end
                     end
                  end
                  MODE_VALUE: begin
                     store_wr.we = conn_ok;
                     if (count_ff < CNT_W'(VALUE_LEN) && rx_byte != CH_SPACE) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        // A space or a full value ends capture with a zero byte.
                        store_wr.data = 8'h00;
                        mode_in       = MODE_AWAIT_END;
                        if (conn_ok) begin
                           flags_in[conn_ff[CIDX_W-1:0]] = 1'b1;
                        end
                     end
                  end
                  MODE_AWAIT_END: begin
                     answer_in  = tok.code;
                     restart_in = restart_ff | tok.ready;
                     if (tok.code == ANS_HDR_END) begin
                        busy_in  = 1'b0;
                        mode_in  = MODE_AWAIT_ANY;
                        count_in = '0;
                     end
                  end
                  default: begin
                     mode_in  = MODE_AWAIT_ANY;
                     count_in = '0;
                  end
               endcase
            end
            KIND_ACK: begin
               if (sel_ok) begin
                  flags_in[conn_sel[CIDX_W-1:0]] = 1'b0;
               end
            end
            KIND_CLEAR: begin
               answer_in = ANS_NONE;
               mode_in   = MODE_AWAIT_ANY;
               flags_in  = '0;
            end
            KIND_READ: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Status as seen after the word, including the selected command.
   always_comb begin
      status.answer  = answer_in;
      status.mode    = mode_in;
      status.busy    = busy_in;
      status.restart = restart_in;
      status.conn    = conn_in;
      status.pending = '0;
      for (int i = 0; i < PEND_W; i++) begin
         if (i < CONNECTIONS) begin
            status.pending[i] = flags_in[i];
         end
      end
      status.command = sel_ok ? cmds_in[conn_sel[CIDX_W-1:0]] : CMD_UNKNOWN;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         mode_ff    <= MODE_AWAIT_ANY;
         count_ff   <= '0;
         conn_ff    <= '0;
         answer_ff  <= ANS_NONE;
         busy_ff    <= 1'b0;
         restart_ff <= 1'b0;
         flags_ff   <= '0;
         for (int i = 0; i < CONNECTIONS; i++) begin
            cmds_ff[i] <= CMD_UNKNOWN;
         end
      end else begin
         window_ff  <= window_in;
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         conn_ff    <= conn_in;
         answer_ff  <= answer_in;
         busy_ff    <= busy_in;
         restart_ff <= restart_in;
         flags_ff   <= flags_in;
         cmds_ff    <= cmds_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/atrrp_store.sv @@
// Per-connection value store with a registered read and write-first forwarding.
`timescale 1ns / 1ps
`default_nettype none

module atrrp_store
   import atrrp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire store_wr_type       store_wr,
   input  wire logic [CONN_W-1:0]  conn_sel,
   input  wire logic [INDEX_W-1:0] value_index,
   output logic [7:0]              value_byte
);

   logic [7:0]         mem [STORE_DEPTH];
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_ok;
   logic [7:0]         rd_ff;
   logic [7:0]         fwd_ff;
   logic               hit_ff;
   logic               ok_ff;

   // Reads outside a connection's slot answer zero.
   assign rd_ok = ({1'b0, conn_sel} < (CONN_W + 1)'(CONNECTIONS))
                  && ((INDEX_W + 7)'(value_index) <= (INDEX_W + 7)'(VALUE_LEN));
   assign rd_addr = store_addr(conn_sel, (CNT_W + 2)'(value_index));

   // Memory write port.
   always_ff @(posedge clock) begin
      if (store_wr.we) begin
         mem[store_wr.addr] <= store_wr.data;
      end
   end

   // Read port; a write to the same entry in the same word is forwarded.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (rd_ok) begin
            rd_ff <= mem[rd_addr];
         end
         fwd_ff <= store_wr.data;
         hit_ff <= store_wr.we && (store_wr.addr == rd_addr);
         ok_ff  <= rd_ok;
      end
   end

   assign value_byte = !ok_ff ? 8'h00 : (hit_ff ? fwd_ff : rd_ff);

endmodule

`default_nettype wire

@@ hw/rtl/at_response_request_parser_top.sv @@
// Top level of the AT response and request parser with its result register.
//
//   channel  direction  data                                          handshake
//   req      in         tdata 16 bits, tuser 2 bits (word kind)       tvalid/tready
//   rsp      out        tdata 32 bits, status and read-back per word  tvalid/tready
//
// Every accepted word gives one result word, registered and valid in the next
// cycle; a word can be accepted every cycle while each result is taken. The
// mode machine and the value store update at the accepting edge, and the store's
// registered read port forms part of the result register. A stalled result
// holds, and a new word is still taken in the cycle the waiting result is taken.
// Reset is synchronous, holds the input off and clears the parser state and the
// result valid flag; the value store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module at_response_request_parser_top
   import atrrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] rx_byte, [10:8] conn_sel, [15:11] value_index
   input  wire logic [15:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] answer_code, [6:4] parse_mode, [7] busy_res, [8] module_restarted,
   // [13:9] pending_requests, [16:14] active_connection, [18:17] conn_command,
   // [26:19] value_byte, [31:27] zero
   output logic [31:0]      rsp_tdata
);

   logic                accept;
   kind_type            kind;
   logic [7:0]          rx_byte;
   logic [CONN_W-1:0]   conn_sel;
   logic [INDEX_W-1:0]  value_index;
   status_type          status;
   store_wr_type        store_wr;
   status_type          res_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          value_byte;

   // Input word fields.
   assign kind        = kind_type'(req_tuser);
   assign rx_byte     = req_tdata[7:0];
   assign conn_sel    = req_tdata[10:8];
   assign value_index = req_tdata[15:11];

   // A word enters out of reset whenever the result register is free or being drained.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   atrrp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (kind),
      .rx_byte  (rx_byte),
      .conn_sel (conn_sel),
      .status   (status),
      .store_wr (store_wr)
   );

   atrrp_store u_store (
      .clock       (clock),
      .enable      (accept),
      .store_wr    (store_wr),
      .conn_sel    (conn_sel),
      .value_index (value_index),
      .value_byte  (value_byte)
   );

   // Result valid flag.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, value_byte, res_ff.command, res_ff.conn, res_ff.pending,
                        res_ff.restart, res_ff.busy, res_ff.mode, res_ff.answer};

endmodule

`default_nettype wire
